// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, ck, rs, expr, msg)
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ----- sv/ipv4_ttl_pkg.sv -----
// Shared constants, types and control structs for the IPv4 TTL rewrite core.
// No dependencies; used by the controller, the datapath and the top level.
package ipv4_ttl_pkg;

  localparam int MAX_HEADER_BYTES = 60;
  localparam int MIN_HEADER_BYTES = 20;
  // IHL * 4 reaches 60, so header counters are six bits wide.
  localparam int HDR_CNT_W = 6;
  localparam int HDR_IDX_W = $clog2(MAX_HEADER_BYTES);
  localparam int SUM_W     = 22;
  localparam int WORD_W    = 16;

  localparam logic [HDR_CNT_W-1:0] TTL_POS     = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] CSUM_HI_POS = HDR_CNT_W'(10);
  localparam logic [HDR_CNT_W-1:0] CSUM_LO_POS = HDR_CNT_W'(11);

  typedef enum logic [1:0] {
    VERD_FWD = 2'd0,
    VERD_BAD = 2'd1,
    VERD_TTL = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_HDR,
    ST_PASS,
    ST_DROP_BAD,
    ST_DROP_TTL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     take_hdr;
    logic     cnt_clear;
    logic     end_hdr;
    logic     load_out;
    verdict_t out_verdict;
    logic     issue;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic bad_ihl;
    logic hdr_end;
    logic ttl_exp;
    logic path_free;
    logic can_issue;
    logic emit_final;
    logic hdr_last;
  } status_t;

endpackage

// ----- sv/ipv4_ttl_dp.sv -----
// Datapath: header store, byte counter, word sum, read stage and output register.
// Depends on ipv4_ttl_pkg; driven by ipv4_ttl_ctrl through cmd_t.
module ipv4_ttl_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  ipv4_ttl_pkg::cmd_t    cmd,
  output ipv4_ttl_pkg::status_t st,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic [1:0]            out_verdict
);

  localparam int CW = ipv4_ttl_pkg::HDR_CNT_W;
  localparam int IW = ipv4_ttl_pkg::HDR_IDX_W;
  localparam int SW = ipv4_ttl_pkg::SUM_W;
  localparam int WW = ipv4_ttl_pkg::WORD_W;
  localparam logic [CW-1:0] LEN_MIN = CW'(ipv4_ttl_pkg::MIN_HEADER_BYTES);
  localparam logic [CW-1:0] LEN_MAX = CW'(ipv4_ttl_pkg::MAX_HEADER_BYTES);

  logic [7:0]    header_store [ipv4_ttl_pkg::MAX_HEADER_BYTES];
  logic [CW-1:0] byte_count;
  logic [CW-1:0] header_length;
  logic [SW-1:0] word_sum;
  logic [7:0]    ttl;
  logic          pkt_last;
  logic [CW-1:0] emit_idx;
  logic          s1_valid;
  logic [7:0]    rd_data;
  logic [CW-1:0] s1_idx;
  logic          s1_last;

  logic [CW-1:0] len_now;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    byte_mod;
  logic [WW-1:0] word_add;
  logic [SW-1:0] word_sum_next;
  logic [WW:0]   fold1;
  logic [WW-1:0] fold2;
  logic [WW-1:0] csum;
  logic          out_free;
  logic          s1_adv;
  logic [7:0]    s1_byte;

  assign len_now = (byte_count == '0) ? {in_byte[3:0], 2'b00} : header_length;
  assign cnt_inc = byte_count + CW'(1);

  // Rewritten header byte as it enters the sum: TTL lowered, checksum zeroed.
  always_comb begin
    if (byte_count == ipv4_ttl_pkg::TTL_POS) begin
      byte_mod = (in_byte != 8'd0) ? in_byte - 8'd1 : 8'd0;
    end else if (byte_count == ipv4_ttl_pkg::CSUM_HI_POS ||
                 byte_count == ipv4_ttl_pkg::CSUM_LO_POS) begin
      byte_mod = 8'd0;
    end else begin
      byte_mod = in_byte;
    end
  end

  assign word_add      = byte_count[0] ? {8'd0, byte_mod} : {byte_mod, 8'd0};
  assign word_sum_next = ((byte_count == '0) ? '0 : word_sum) + SW'(word_add);

  // End-around fold: two passes bring a 22-bit sum down to 16 bits.
  assign fold1 = (WW+1)'(word_sum[WW-1:0]) + (WW+1)'(word_sum[SW-1:WW]);
  assign fold2 = fold1[WW-1:0] + WW'(fold1[WW]);
  assign csum  = ~fold2;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;

  always_comb begin
    st.first      = (byte_count == '0);
    st.bad_ihl    = (byte_count == '0) && (len_now < LEN_MIN || len_now > LEN_MAX);
    st.hdr_end    = (cnt_inc == len_now);
    st.ttl_exp    = (ttl <= 8'd1);
    st.path_free  = !s1_valid && out_free;
    st.can_issue  = !s1_valid || s1_adv;
    st.emit_final = (emit_idx == header_length - CW'(1));
    st.hdr_last   = pkt_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hdr) begin
      header_store[byte_count[IW-1:0]] <= in_byte;
    end
    if (cmd.issue) begin
      rd_data <= header_store[emit_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      header_length <= '0;
      word_sum      <= '0;
    end else begin
      if (cmd.cnt_clear) begin
        byte_count <= '0;
      end else if (cmd.take_hdr) begin
        byte_count <= cnt_inc;
      end
      if (cmd.take_hdr) begin
        word_sum <= word_sum_next;
        if (byte_count == '0) begin
          header_length <= len_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hdr && byte_count == ipv4_ttl_pkg::TTL_POS) begin
      ttl <= in_byte;
    end
    if (cmd.end_hdr) begin
      pkt_last <= in_last;
    end
    if (cmd.issue) begin
      s1_idx  <= emit_idx;
      s1_last <= pkt_last && st.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cmd.end_hdr) begin
        emit_idx <= '0;
      end else if (cmd.issue) begin
        emit_idx <= emit_idx + CW'(1);
      end
      if (cmd.issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Patch TTL and checksum bytes on their way out of the store.
  always_comb begin
    if (s1_idx == ipv4_ttl_pkg::TTL_POS) begin
      s1_byte = ttl - 8'd1;
    end else if (s1_idx == ipv4_ttl_pkg::CSUM_HI_POS) begin
      s1_byte = csum[WW-1:8];
    end else if (s1_idx == ipv4_ttl_pkg::CSUM_LO_POS) begin
      s1_byte = csum[7:0];
    end else begin
      s1_byte = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv || cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte    <= s1_byte;
      out_last    <= s1_last;
      out_verdict <= ipv4_ttl_pkg::VERD_FWD;
    end else if (cmd.load_out) begin
      if (cmd.out_verdict == ipv4_ttl_pkg::VERD_FWD) begin
        out_byte <= in_byte;
        out_last <= in_last;
      end else begin
        out_byte <= 8'd0;
        out_last <= 1'b1;
      end
      out_verdict <= cmd.out_verdict;
    end
  end

endmodule

// ----- sv/ipv4_ttl_ctrl.sv -----
// Controller: packet phase state machine that sequences the datapath.
// Depends on ipv4_ttl_pkg; pairs with ipv4_ttl_dp.
module ipv4_ttl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_last,
  input  ipv4_ttl_pkg::status_t st,
  output ipv4_ttl_pkg::cmd_t    cmd
);

  ipv4_ttl_pkg::state_t state;
  ipv4_ttl_pkg::state_t state_next;
  logic                 accept;

  assign in_ready = (state != ipv4_ttl_pkg::ST_EMIT) && st.path_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipv4_ttl_pkg::ST_HDR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.out_verdict = ipv4_ttl_pkg::VERD_FWD;
    case (state)
      ipv4_ttl_pkg::ST_HDR: begin
        if (accept) begin
          if (st.bad_ihl) begin
            if (in_last) begin
              cmd.load_out    = 1'b1;
              cmd.out_verdict = ipv4_ttl_pkg::VERD_BAD;
            end else begin
              state_next = ipv4_ttl_pkg::ST_DROP_BAD;
            end
          end else begin
            cmd.take_hdr = 1'b1;
            if (st.hdr_end) begin
              cmd.cnt_clear = 1'b1;
              if (st.ttl_exp) begin
                if (in_last) begin
                  cmd.load_out    = 1'b1;
                  cmd.out_verdict = ipv4_ttl_pkg::VERD_TTL;
                end else begin
                  state_next = ipv4_ttl_pkg::ST_DROP_TTL;
                end
              end else begin
                cmd.end_hdr = 1'b1;
                state_next  = ipv4_ttl_pkg::ST_EMIT;
              end
            end else if (in_last) begin
              cmd.cnt_clear   = 1'b1;
              cmd.load_out    = 1'b1;
              cmd.out_verdict = ipv4_ttl_pkg::VERD_BAD;
            end
          end
        end
      end
      ipv4_ttl_pkg::ST_PASS: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          if (in_last) begin
            state_next = ipv4_ttl_pkg::ST_HDR;
          end
        end
      end
      ipv4_ttl_pkg::ST_DROP_BAD: begin
        if (accept && in_last) begin
          cmd.load_out    = 1'b1;
          cmd.out_verdict = ipv4_ttl_pkg::VERD_BAD;
          state_next      = ipv4_ttl_pkg::ST_HDR;
        end
      end
      ipv4_ttl_pkg::ST_DROP_TTL: begin
        if (accept && in_last) begin
          cmd.load_out    = 1'b1;
          cmd.out_verdict = ipv4_ttl_pkg::VERD_TTL;
          state_next      = ipv4_ttl_pkg::ST_HDR;
        end
      end
      ipv4_ttl_pkg::ST_EMIT: begin
        if (st.can_issue) begin
          cmd.issue = 1'b1;
          if (st.emit_final) begin
            // A header that closed the packet leaves no payload to pass.
            if (st.hdr_last) begin
              state_next = ipv4_ttl_pkg::ST_HDR;
            end else begin
              state_next = ipv4_ttl_pkg::ST_PASS;
            end
          end
        end
      end
      default: begin
        state_next = ipv4_ttl_pkg::ST_HDR;
      end
    endcase
  end

endmodule

// ----- sv/ipv4_ttl_checksum_rewrite_core.sv -----
// Top level of the IPv4 TTL decrement and header checksum rewrite core.
// Depends on ipv4_ttl_pkg, ipv4_ttl_ctrl, ipv4_ttl_dp and assert_macros.svh.
//
//   Channel   Direction  Signals                          Contents
//   s_axis    in         tvalid tready tdata[7:0] tlast   packet byte, last mark
//   m_axis    out        tvalid tready tdata[7:0] tlast   byte, last mark,
//                        tuser[1:0]                       verdict
//
// While m_axis accepts, header bytes go in at one per cycle, a good header drains
// from the header store at one byte per cycle through a registered read, and
// payload beats pass at one per cycle. No input beat is taken while the header
// drains; nothing but a drop verdict comes out until the header ends.
// Reset (rst, synchronous) returns to awaiting a header; the store needs no clear.
// A stall on m_axis holds the output register and, through it, s_axis.
`include "assert_macros.svh"

module ipv4_ttl_checksum_rewrite_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [1:0] verdict
);

  ipv4_ttl_pkg::cmd_t    cmd;
  ipv4_ttl_pkg::status_t st;

  // Phase sequencing: header collect, emit, pass, discard.
  ipv4_ttl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_last  (s_axis_tlast),
    .st       (st),
    .cmd      (cmd)
  );

  // Store, sum, checksum fold and the output register.
  ipv4_ttl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_verdict (m_axis_tuser)
  );

  // A drop verdict is a single zero beat that closes the packet.
  `ASSERT_IMPLIES(a_verdict_beat, clk, rst, m_axis_tvalid && m_axis_tuser != ipv4_ttl_pkg::VERD_FWD, m_axis_tlast && m_axis_tdata == 8'd0, "drop verdict beat not last or nonzero")
  // While the header drains, the input side stays closed.
  `ASSERT_IMPLIES(a_emit_blocks_input, clk, rst, cmd.issue, !s_axis_tready, "input open during header emission")
  // Header end resets the byte counter for the next packet.
  `ASSERT_NEXT(a_hdr_end_clears, clk, rst, cmd.end_hdr, st.first, "byte counter not cleared at header end")

endmodule
